[design/text_console_writer_core_defines.svh]
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcw: check failed");
`define TCW_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define TCW_ASSERT(label, prop)
`define TCW_ASSERT_MSG(label, prop, msg)
`endif
`endif

[design/tcw_pkg.sv]
package tcw_pkg;

    localparam int ADDR_W = 13;
    localparam int N_W    = 14;
    localparam int CELLS  = 1 << ADDR_W;

    localparam logic [7:0] MAX_COLS   = 8'd128;
    localparam logic [6:0] MAX_ROWS   = 7'd64;
    localparam logic [6:0] MIN_ROWS   = 7'd2;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET = 7'd25;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_ATTRIBUTE = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_ZERO  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [12:0] cell_index;
    } tcw_req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
        logic       scrolled;
    } tcw_rsp_t;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       finish;
        logic [1:0] mode;
    } tcw_cmd_t;

    typedef struct packed {
        logic op_put;
        logic op_clear;
        logic scroll;
        logic last;
    } tcw_sts_t;

endpackage

[design/tcw_ctrl.sv]
`include "text_console_writer_core_defines.svh"

module tcw_ctrl import tcw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  tcw_sts_t sts,
    output tcw_cmd_t cmd,
    output logic     busy,
    output logic     done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_ZERO  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mode   = MODE_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.op_put && sts.scroll)
                begin
                    state_next = S_COPY;
                end
                else if (sts.op_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                cmd.mode = MODE_COPY;
                if (sts.last)
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.mode = MODE_ZERO;
                if (sts.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last masked write of the bottom row lands here
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.mode = MODE_CLEAR;
                if (sts.last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `TCW_ASSERT(a_done_after_busy, done |-> $past(busy))
    `TCW_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy)
    `TCW_ASSERT_MSG(a_finish_once, done |-> !$past(done), "tcw: back-to-back done")

endmodule

[design/tcw_datapath.sv]
`include "text_console_writer_core_defines.svh"

module tcw_datapath import tcw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  tcw_req_t req,
    input  tcw_cmd_t cmd,
    output tcw_sts_t sts,
    output tcw_rsp_t rsp,
    input  logic     cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // configuration
    logic [7:0] columns_reg, attribute_reg;
    logic [6:0] rows_reg;
    logic [7:0] nc;
    logic [6:0] nr, nr_m1;

    // cursor
    logic [7:0] cur_col_reg, cur_col_next;
    logic [5:0] cur_row_reg, cur_row_next;
    logic       scrolled_reg, scrolled_next;

    // latched request and precomputed put target
    logic [1:0]        op_reg;
    logic [7:0]        ch_reg;
    logic [7:0]        p_wcol_reg, p_wcol_next;
    logic [6:0]        p_wrow_reg, p_wrow_next;
    logic [ADDR_W-1:0] p_addr_reg, p_addr_next;
    logic              p_wr_ok_reg, p_wr_ok_next;
    logic              wrap;
    logic [14:0]       addr_full;

    // put result
    logic       is_nl, is_cr, put_we, put_scroll;
    logic [6:0] rowx, row_dec, row_fin;
    logic [7:0] col_fin;

    // sweep
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [N_W-1:0]    n_reg, n_calc, last_base;
    logic              last;
    logic              wp_valid_reg, wp_valid_next;
    logic [ADDR_W-1:0] wp_addr_reg, wp_addr_next;
    logic              wp_keep_reg, wp_keep_next;

    // cell store
    logic [15:0]       mem [CELLS];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_we;

    tcw_rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= COLS_RESET;
            rows_reg      <= ROWS_RESET;
            attribute_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:   columns_reg   <= cfg_data;
                CFG_ROWS:      rows_reg      <= cfg_data[6:0];
                CFG_ATTRIBUTE: attribute_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (columns_reg == 8'd0)
            nc = 8'd1;
        else if (columns_reg > MAX_COLS)
            nc = MAX_COLS;
        else
            nc = columns_reg;

        if (rows_reg < MIN_ROWS)
            nr = MIN_ROWS;
        else if (rows_reg > MAX_ROWS)
            nr = MAX_ROWS;
        else
            nr = rows_reg;
    end

    assign nr_m1  = nr - 7'd1;
    assign n_calc = {6'd0, nc} * {7'd0, nr};

    // wrap and cell address from the idle cursor, captured with the request
    assign wrap         = (cur_col_reg >= nc);
    assign p_wcol_next  = wrap ? 8'd0 : cur_col_reg;
    assign p_wrow_next  = {1'b0, cur_row_reg} + {6'd0, wrap};
    assign addr_full    = {8'd0, p_wrow_next} * {7'd0, nc} + {7'd0, p_wcol_next};
    assign p_addr_next  = addr_full[ADDR_W-1:0];
    assign p_wr_ok_next = (p_wrow_next < nr);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg      <= req.opcode;
            ch_reg      <= req.char_code;
            p_wcol_reg  <= p_wcol_next;
            p_wrow_reg  <= p_wrow_next;
            p_addr_reg  <= p_addr_next;
            p_wr_ok_reg <= p_wr_ok_next;
        end
    end

    assign is_nl      = (ch_reg == CH_NEWLINE);
    assign is_cr      = (ch_reg == CH_RETURN);
    assign put_we     = cmd.exec && (op_reg == OP_PUT) && !is_nl && !is_cr && p_wr_ok_reg;
    assign rowx       = p_wrow_reg + {6'd0, is_nl};
    assign put_scroll = (rowx >= nr_m1);
    assign row_dec    = put_scroll ? (rowx - 7'd1) : rowx;
    assign row_fin    = (row_dec > nr_m1) ? nr_m1 : row_dec;

    always_comb
    begin
        if (is_nl)
            col_fin = p_wcol_reg;
        else if (is_cr)
            col_fin = 8'd0;
        else
            col_fin = p_wcol_reg + 8'd1;
    end

    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        scrolled_next = scrolled_reg;
        if (cmd.exec)
        begin
            scrolled_next = 1'b0;
            if (op_reg == OP_PUT)
            begin
                cur_col_next  = col_fin;
                cur_row_next  = row_fin[5:0];
                scrolled_next = put_scroll;
            end
            else if (op_reg == OP_CLEAR)
            begin
                cur_col_next = 8'd0;
                cur_row_next = 6'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg  <= 8'd0;
            cur_row_reg  <= 6'd0;
            scrolled_reg <= 1'b0;
            wp_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
            scrolled_reg <= scrolled_next;
            wp_valid_reg <= wp_valid_next;
        end
    end

    // sweep pointer: copy reads rows 1.. and writes each one row up in the next cycle,
    // then the bottom row is reread and written back with its chars zeroed
    assign last      = (({1'b0, ptr_reg} + 14'd1) == n_reg);
    assign last_base = n_reg - {6'd0, nc};

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.exec)
            ptr_next = (op_reg == OP_PUT) ? ADDR_W'(nc) : '0;
        else if (cmd.mode == MODE_COPY)
            ptr_next = last ? last_base[ADDR_W-1:0] : (ptr_reg + 1'b1);
        else if (cmd.mode == MODE_ZERO || cmd.mode == MODE_CLEAR)
            ptr_next = ptr_reg + 1'b1;
    end

    assign wp_valid_next = (cmd.mode == MODE_COPY) || (cmd.mode == MODE_ZERO);
    assign wp_addr_next  = (cmd.mode == MODE_COPY) ? (ptr_reg - ADDR_W'(nc)) : ptr_reg;
    assign wp_keep_next  = (cmd.mode == MODE_COPY);

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        wp_addr_reg <= wp_addr_next;
        wp_keep_reg <= wp_keep_next;
        if (cmd.exec)
            n_reg <= n_calc;
    end

    // idle reads go to the requested cell, so read data is ready in exec
    assign mem_raddr = (cmd.mode == MODE_NONE) ? req.cell_index : ptr_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_addr_reg;
        mem_wdata = wp_keep_reg ? rd_data_reg : {rd_data_reg[15:8], 8'h00};
        if (wp_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (put_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = p_addr_reg;
            mem_wdata = {attribute_reg, ch_reg};
        end
        else if (cmd.mode == MODE_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg;
            mem_wdata = {attribute_reg, 8'h00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.cell_char  <= (op_reg == OP_READ) ? rd_data_reg[7:0] : 8'd0;
            rsp_reg.cell_attr  <= (op_reg == OP_READ) ? rd_data_reg[15:8] : 8'd0;
            rsp_reg.cursor_col <= cur_col_next;
            rsp_reg.cursor_row <= cur_row_next;
            rsp_reg.scrolled   <= scrolled_next;
        end
    end

    assign rsp          = rsp_reg;
    assign sts.op_put   = (op_reg == OP_PUT);
    assign sts.op_clear = (op_reg == OP_CLEAR);
    assign sts.scroll   = put_scroll;
    assign sts.last     = last;

    `TCW_ASSERT(a_wp_below_ptr,
        (wp_valid_reg && (cmd.mode == MODE_COPY || cmd.mode == MODE_ZERO)) |-> (wp_addr_reg < ptr_reg))
    `TCW_ASSERT_MSG(a_clear_no_pending, (cmd.mode == MODE_CLEAR) |-> !wp_valid_reg,
        "tcw: copy write pending during clear")

endmodule

[design/text_console_writer_core.sv]
// Text console writer: cell store of char/attribute pairs plus a cursor.
// Requests: opcode (put, read, clear, nop), char_code, cell_index on req,
// taken on a clock edge with start high and busy low.
// Each request yields one response on rsp, valid for the single cycle in
// which done is high; the receiver cannot hold it off.
// Config: cfg_we with cfg_index (columns, rows, attribute) and cfg_data,
// written on the edge; only write while busy is low.
// Controller states a request passes through after it is taken:
//   put without scroll, read, nop : exec
//   clear                         : exec, clear (one per in-use cell)
//   put that scrolls              : exec, copy, zero, drain
// Scroll and clear walk the in-use cells one per cycle through the single
// write port of the store; a scroll copies each row up through a registered
// read-to-write pipe and then rewrites the bottom row with chars zeroed.
// done rises in the cycle after the last store write of the request; busy is
// low in that cycle, so a new request can be taken in it.
// Reset homes the cursor and loads columns 80, rows 25, attribute 7; the
// store contents are undefined until cleared or written.
module text_console_writer_core import tcw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  tcw_req_t   req,
    output logic       busy,
    output logic       done,
    output tcw_rsp_t   rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    tcw_cmd_t cmd;
    tcw_sts_t sts;

    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    tcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int N_PHASES = 9;
    localparam int MAX_PRINTS = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    tcw_req_t   req = '0;
    logic       busy;
    logic       done;
    tcw_rsp_t   rsp;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_COLUMNS;
    logic [7:0] cfg_data = '0;

    // console image as the block should hold it
    logic [15:0] screen_img [0:CELLS-1];
    int          img_col = 0;
    int          img_row = 0;
    logic [7:0]  cols_reg = COLS_RESET;
    logic [6:0]  rows_reg = ROWS_RESET;
    logic [7:0]  attr_reg = ATTR_RESET;

    tcw_req_t pending_reqs [$];
    tcw_rsp_t expected_rsps [$];

    int idle_pct = 33;
    int n_errors = 0;
    int n_checked = 0;
    int n_scrolls = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_settings = 1;

    // random phases: raw register values, read window, newline and clear weights, lengths, idle
    int ph_cols [N_PHASES] = '{80, 1, 0, 8, 255, 16, 40, 200, 3};
    int ph_rows [N_PHASES] = '{25, 2, 0, 4, 127, 64, 1, 10, 7};
    int ph_attr [N_PHASES] = '{8'h1F, 8'h00, 8'hFF, 8'h3C, 8'hA5, 8'h4E, 8'h70, 8'h81, 8'h5A};
    int ph_area [N_PHASES] = '{2000, 2, 2, 32, 8192, 1024, 80, 1280, 21};
    int ph_nl   [N_PHASES] = '{15, 10, 10, 15, 80, 30, 10, 15, 20};
    int ph_clr  [N_PHASES] = '{4, 4, 4, 4, 0, 3, 4, 3, 4};
    int ph_len  [N_PHASES] = '{130, 110, 80, 150, 140, 140, 100, 100, 100};
    int ph_idle [N_PHASES] = '{33, 33, 33, 63, 63, 63, 0, 0, 0};

    text_console_writer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // advance the console image by one request, return what the block must report
    function automatic tcw_rsp_t console_step(tcw_req_t r);
        tcw_rsp_t res;
        int nc;
        int nr;
        int col;
        int row;
        res = '0;
        nc = int'(cols_reg);
        if (nc < 1) nc = 1;
        if (nc > int'(MAX_COLS)) nc = int'(MAX_COLS);
        nr = int'(rows_reg);
        if (nr < int'(MIN_ROWS)) nr = int'(MIN_ROWS);
        if (nr > int'(MAX_ROWS)) nr = int'(MAX_ROWS);
        case (r.opcode)
            OP_PUT:
            begin
                col = img_col;
                row = img_row;
                if (col >= nc)
                begin
                    col = 0;
                    row++;
                end
                if (r.char_code == CH_NEWLINE)
                    row++;
                else if (r.char_code == CH_RETURN)
                    col = 0;
                else
                begin
                    // a row below the in-use screen drops the write
                    if (row < nr)
                        screen_img[row * nc + col] = {attr_reg, r.char_code};
                    col++;
                end
                if (row >= nr - 1)
                begin
                    for (int y = 1; y < nr; y++)
                        for (int x = 0; x < nc; x++)
                            screen_img[(y - 1) * nc + x] = screen_img[y * nc + x];
                    for (int x = 0; x < nc; x++)
                        screen_img[(nr - 1) * nc + x][7:0] = 8'h00;
                    row--;
                    res.scrolled = 1'b1;
                end
                if (row > nr - 1)
                    row = nr - 1;
                img_col = col;
                img_row = row;
            end
            OP_READ:
            begin
                res.cell_char = screen_img[r.cell_index][7:0];
                res.cell_attr = screen_img[r.cell_index][15:8];
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < nc * nr; i++)
                    screen_img[i] = {attr_reg, 8'h00};
                img_col = 0;
                img_row = 0;
            end
            default: ;
        endcase
        res.cursor_col = img_col[7:0];
        res.cursor_row = img_row[5:0];
        return res;
    endfunction

    function automatic tcw_req_t make_req(logic [1:0] op, logic [7:0] ch, logic [12:0] idx);
        tcw_req_t r;
        r.opcode = op;
        r.char_code = ch;
        r.cell_index = idx;
        return r;
    endfunction

    // mostly text with line breaks; reads favor the in-use window
    function automatic tcw_req_t rand_req(int nl_pct, int clr_pct, int area);
        tcw_req_t r;
        int pick;
        int sub;
        pick = $urandom_range(99);
        sub = $urandom_range(99);
        r.char_code = 8'($urandom_range(255));
        r.cell_index = 13'($urandom_range(CELLS - 1));
        if (pick < 74)
        begin
            r.opcode = OP_PUT;
            if (sub < nl_pct)
                r.char_code = CH_NEWLINE;
            else if (sub < nl_pct + 8)
                r.char_code = CH_RETURN;
        end
        else if (pick < 90)
        begin
            r.opcode = OP_READ;
            if (sub < 70)
                r.cell_index = 13'($urandom_range(area - 1));
        end
        else if (pick < 100 - clr_pct)
            r.opcode = OP_NOP;
        else
            r.opcode = OP_CLEAR;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (n_errors < MAX_PRINTS)
            $display("testbench: mismatch on %s: got %0h, expected %0h at %0t",
                     what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COLUMNS:   cols_reg = val;
            CFG_ROWS:      rows_reg = val[6:0];
            CFG_ATTRIBUTE: attr_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_screen(int c, int r, int a);
        write_reg(CFG_COLUMNS, 8'(c));
        write_reg(CFG_ROWS, 8'(r));
        write_reg(CFG_ATTRIBUTE, 8'(a));
        n_settings++;
        @(negedge clk);
    endtask

    // sender holds off until every pending request has answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(console_step(req));
                if (req.opcode == OP_READ) n_reads++;
                if (req.opcode == OP_CLEAR) n_clears++;
            end
            if (!(start && busy))
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : monitor
        tcw_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
                report_mismatch("result with no request pending", int'(rsp), 0);
            else
            begin
                want = expected_rsps.pop_front();
                n_checked++;
                if (want.scrolled) n_scrolls++;
                if (rsp.cell_char !== want.cell_char)
                    report_mismatch("cell_char", int'(rsp.cell_char), int'(want.cell_char));
                if (rsp.cell_attr !== want.cell_attr)
                    report_mismatch("cell_attr", int'(rsp.cell_attr), int'(want.cell_attr));
                if (rsp.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", int'(rsp.cursor_col),
                                    int'(want.cursor_col));
                if (rsp.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", int'(rsp.cursor_row),
                                    int'(want.cursor_row));
                if (rsp.scrolled !== want.scrolled)
                    report_mismatch("scrolled", int'(rsp.scrolled), int'(want.scrolled));
            end
        end
    end

    initial
    begin
        #100ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry, no reads: the store is still unknown
        pending_reqs.push_back(make_req(OP_PUT, 8'h48, '0));
        pending_reqs.push_back(make_req(OP_PUT, CH_RETURN, '0));
        pending_reqs.push_back(make_req(OP_PUT, CH_NEWLINE, '0));
        wait_drained();

        // full-size clear leaves every cell defined for the rest of the run
        set_screen(MAX_COLS, MAX_ROWS, 8'hFF);
        pending_reqs.push_back(make_req(OP_CLEAR, 8'h00, '0));
        pending_reqs.push_back(make_req(OP_PUT, 8'h00, '0));
        pending_reqs.push_back(make_req(OP_PUT, 8'hFF, '0));
        pending_reqs.push_back(make_req(OP_READ, 8'h00, 13'd0));
        pending_reqs.push_back(make_req(OP_READ, 8'hFF, 13'd1));
        pending_reqs.push_back(make_req(OP_READ, 8'h00, 13'h1FFF));
        pending_reqs.push_back(make_req(OP_READ, 8'hAA, 13'h1555));
        wait_drained();

        // tiny screen: wrap, scroll, wrap plus newline, clear
        set_screen(2, 3, 8'h00);
        pending_reqs.push_back(make_req(OP_PUT, 8'h61, '0));
        pending_reqs.push_back(make_req(OP_PUT, 8'h62, '0));
        pending_reqs.push_back(make_req(OP_PUT, 8'h63, '0));
        pending_reqs.push_back(make_req(OP_PUT, CH_NEWLINE, '0));
        pending_reqs.push_back(make_req(OP_PUT, CH_RETURN, '0));
        pending_reqs.push_back(make_req(OP_READ, 8'h00, 13'd0));
        pending_reqs.push_back(make_req(OP_READ, 8'h00, 13'd4));
        pending_reqs.push_back(make_req(OP_PUT, 8'h78, '0));
        pending_reqs.push_back(make_req(OP_PUT, 8'h79, '0));
        pending_reqs.push_back(make_req(OP_PUT, CH_NEWLINE, '0));
        pending_reqs.push_back(make_req(OP_CLEAR, 8'h00, '0));
        pending_reqs.push_back(make_req(OP_READ, 8'h00, 13'd5));
        pending_reqs.push_back(make_req(OP_NOP, 8'h55, 13'h0AAA));
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_screen(ph_cols[p], ph_rows[p],
                       (p == 3) ? $urandom_range(255) : ph_attr[p]);
            idle_pct = ph_idle[p];
            for (int n = 0; n < ph_len[p]; n++)
                pending_reqs.push_back(rand_req(ph_nl[p], ph_clr[p], ph_area[p]));
            wait_drained();
        end
        repeat (40) @(posedge clk);

        $display("testbench: %0d results checked over %0d screen settings", n_checked, n_settings);
        $display("testbench: %0d scrolls, %0d clears, %0d cell reads", n_scrolls, n_clears,
                 n_reads);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer_core.sv
tb/testbench.sv
